// ----- rtl/core/pat_pkg.sv -----
`timescale 1ns / 1ps

package pat_pkg;

  // Operation codes
  localparam logic [3:0] MODE_LOOKUP  = 4'd0;
  localparam logic [3:0] MODE_ADD     = 4'd1;
  localparam logic [3:0] MODE_REMOVE  = 4'd2;
  localparam logic [3:0] MODE_CONFIRM = 4'd3;
  localparam logic [3:0] MODE_DENY    = 4'd4;
  localparam logic [3:0] MODE_PENDING = 4'd5;
  localparam logic [3:0] MODE_CLEAR   = 4'd6;
  localparam logic [3:0] MODE_DEMOTE  = 4'd7;
  localparam logic [3:0] MODE_READ    = 4'd8;

  // Status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_INVALID  = 3'd1;
  localparam logic [2:0] STATUS_PRESENT  = 3'd2;
  localparam logic [2:0] STATUS_FULL     = 3'd3;
  localparam logic [2:0] STATUS_NOTFOUND = 3'd4;

  // Trust states
  localparam logic [1:0] TRUST_PENDING   = 2'd0;
  localparam logic [1:0] TRUST_CONFIRMED = 2'd1;
  localparam logic [1:0] TRUST_DENIED    = 2'd2;

  localparam logic [1:0]  VIA_NONE = 2'd0;
  localparam logic [31:0] ID_ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  trust;
    logic [1:0]  transport;
    logic [31:0] verified;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] node_id;
    logic [1:0]  via;
    logic [31:0] epoch_now;
    logic [3:0]  slot;
  } op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [1:0]  peer_state;
    logic        may_open;
    logic        is_confirmed;
    logic [1:0]  transport;
    logic [31:0] verified;
    logic [31:0] peer;
    logic [4:0]  count;
  } result_t;

  function automatic logic id_ok(logic [31:0] id);
    return (id != '0) && (id != ID_ALL_ONES);
  endfunction

  // Build a response; entry fields stay zero when nothing was found
  function automatic result_t make_result(logic [2:0] status, logic found, entry_t e);
    result_t r;
    r = '0;
    r.status = status;
    if (found) begin
      r.found        = 1'b1;
      r.peer_state   = e.trust;
      r.may_open     = (e.trust != TRUST_DENIED);
      r.is_confirmed = (e.trust == TRUST_CONFIRMED);
      r.transport    = e.transport;
      r.verified     = e.verified;
      r.peer         = e.id;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pat_req_if.sv -----
`timescale 1ns / 1ps

interface pat_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] node_id;
  logic [1:0]  via;
  logic [31:0] epoch_now;
  logic [3:0]  slot;

  modport source (output valid, mode, node_id, via, epoch_now, slot, input ready);
  modport sink   (input valid, mode, node_id, via, epoch_now, slot, output ready);
endinterface

// ----- rtl/core/pat_rsp_if.sv -----
`timescale 1ns / 1ps

interface pat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [1:0]  peer_state;
  logic        may_open;
  logic        is_confirmed;
  logic [1:0]  transport_out;
  logic [31:0] verified_out;
  logic [31:0] peer_out;
  logic [4:0]  count_out;

  modport source (output valid, status, found, peer_state, may_open, is_confirmed,
                  transport_out, verified_out, peer_out, count_out, input ready);
  modport sink   (input valid, status, found, peer_state, may_open, is_confirmed,
                  transport_out, verified_out, peer_out, count_out, output ready);
endinterface

// ----- rtl/core/pat_ram.sv -----
`timescale 1ns / 1ps

module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pat_ctrl.sv -----
`timescale 1ns / 1ps

module pat_ctrl
  import pat_pkg::*;
#(
  parameter int MAX_PEERS = 16,
  localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
  localparam int CNT_W = $clog2(MAX_PEERS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  op_t              op_in,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic [IDX_W-1:0] raddr,
  input  entry_t           rdata,
  output logic             we,
  output logic [IDX_W-1:0] waddr,
  output entry_t           wdata
);

  localparam int SW = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_DEMOTE = 6'b001000,
    S_READ   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] issue, issue_next;
  logic             rd_v, rd_v_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  result_t          res_q, res_next;
  logic             all_issued;
  logic             hit_now;
  entry_t           upd;

  assign all_issued = (issue >= count);
  // Shared compare unit: one stored id against the request id per cycle
  assign hit_now    = rd_v && (rdata.id == op.node_id);
  assign op_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_RESP);
  assign res        = res_q;

  always_comb begin
    state_next  = state;
    op_next     = op;
    count_next  = count;
    issue_next  = issue;
    rd_v_next   = rd_v;
    rd_idx_next = rd_idx;
    res_next    = res_q;
    raddr       = issue[IDX_W-1:0];
    we          = 1'b0;
    waddr       = rd_idx;
    wdata       = rdata;
    upd         = rdata;

    unique case (state)
      S_IDLE: begin
        if (op_valid) begin
          op_next    = op_in;
          issue_next = '0;
          rd_v_next  = 1'b0;
          unique case (op_in.mode)
            MODE_LOOKUP, MODE_ADD, MODE_REMOVE, MODE_CONFIRM, MODE_DENY,
            MODE_PENDING: begin
              if (id_ok(op_in.node_id)) begin
                state_next = S_SCAN;
              end else begin
                res_next   = make_result(STATUS_INVALID, 1'b0, '0);
                state_next = S_RESP;
              end
            end
            MODE_CLEAR: begin
              count_next = '0;
              res_next   = make_result(STATUS_OK, 1'b0, '0);
              state_next = S_RESP;
            end
            MODE_DEMOTE: begin
              state_next = S_DEMOTE;
            end
            MODE_READ: begin
              if (SW'(op_in.slot) < SW'(count)) begin
                state_next = S_READ;
              end else begin
                res_next   = make_result(STATUS_NOTFOUND, 1'b0, '0);
                state_next = S_RESP;
              end
            end
            default: begin
              res_next   = make_result(STATUS_OK, 1'b0, '0);
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Advance the read pointer one entry a cycle
        if (!all_issued) begin
          rd_v_next   = 1'b1;
          rd_idx_next = issue[IDX_W-1:0];
          issue_next  = issue + CNT_W'(1);
        end else begin
          rd_v_next = 1'b0;
        end
        if (hit_now) begin
          state_next = S_RESP;
          unique case (op.mode)
            MODE_REMOVE: begin
              // Start compaction just past the hit
              issue_next = CNT_W'(rd_idx) + CNT_W'(1);
              rd_v_next  = 1'b0;
              state_next = S_SHIFT;
            end
            MODE_ADD: begin
              res_next = make_result(STATUS_PRESENT, 1'b1, rdata);
            end
            MODE_CONFIRM: begin
              upd.trust     = TRUST_CONFIRMED;
              upd.transport = op.via;
              upd.verified  = op.epoch_now;
              we            = 1'b1;
              wdata         = upd;
              res_next      = make_result(STATUS_OK, 1'b1, upd);
            end
            MODE_DENY: begin
              upd.trust = TRUST_DENIED;
              we        = 1'b1;
              wdata     = upd;
              res_next  = make_result(STATUS_OK, 1'b1, upd);
            end
            MODE_PENDING: begin
              upd.trust = TRUST_PENDING;
              we        = 1'b1;
              wdata     = upd;
              res_next  = make_result(STATUS_OK, 1'b1, upd);
            end
            default: begin
              res_next = make_result(STATUS_OK, 1'b1, rdata);
            end
          endcase
        end else if (all_issued) begin
          state_next = S_RESP;
          if (op.mode == MODE_ADD) begin
            if (count >= CNT_W'(MAX_PEERS)) begin
              res_next = make_result(STATUS_FULL, 1'b0, '0);
            end else begin
              // Append the new id as pending
              upd.id        = op.node_id;
              upd.trust     = TRUST_PENDING;
              upd.transport = VIA_NONE;
              upd.verified  = '0;
              we            = 1'b1;
              waddr         = count[IDX_W-1:0];
              wdata         = upd;
              count_next    = count + CNT_W'(1);
              res_next      = make_result(STATUS_OK, 1'b1, upd);
            end
          end else begin
            res_next = make_result(STATUS_NOTFOUND, 1'b0, '0);
          end
        end
      end

      S_SHIFT: begin
        // Move each later entry down by one
        if (!all_issued) begin
          rd_v_next   = 1'b1;
          rd_idx_next = issue[IDX_W-1:0];
          issue_next  = issue + CNT_W'(1);
        end else begin
          rd_v_next = 1'b0;
        end
        if (rd_v) begin
          we    = 1'b1;
          waddr = rd_idx - IDX_W'(1);
        end else if (all_issued) begin
          count_next = count - CNT_W'(1);
          res_next   = make_result(STATUS_OK, 1'b0, '0);
          state_next = S_RESP;
        end
      end

      S_DEMOTE: begin
        // Drop every confirmed entry back to pending
        if (!all_issued) begin
          rd_v_next   = 1'b1;
          rd_idx_next = issue[IDX_W-1:0];
          issue_next  = issue + CNT_W'(1);
        end else begin
          rd_v_next = 1'b0;
        end
        if (rd_v) begin
          upd.trust = TRUST_PENDING;
          wdata     = upd;
          we        = (rdata.trust == TRUST_CONFIRMED);
        end else if (all_issued) begin
          res_next   = make_result(STATUS_OK, 1'b0, '0);
          state_next = S_RESP;
        end
      end

      S_READ: begin
        raddr = IDX_W'(op.slot);
        if (!rd_v) begin
          rd_v_next = 1'b1;
        end else begin
          res_next   = make_result(STATUS_OK, 1'b1, rdata);
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Stamp the entry count after the operation
    if (state != S_RESP && state_next == S_RESP) begin
      res_next.count = 5'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_v  <= rd_v_next;
    end
    op     <= op_next;
    issue  <= issue_next;
    rd_idx <= rd_idx_next;
    res_q  <= res_next;
  end

endmodule

// ----- rtl/core/peer_access_table_top.sv -----
`timescale 1ns / 1ps
// Throughput: one request at a time; a new request is accepted only once the previous one
// has left the controller. Scans, compaction and demote are paced by the single table read
// port stepping one entry a cycle.
// Reset: the entry count and control are cleared at once; table words are not swept.

module peer_access_table_top
  import pat_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  logic      clk,
  input  logic      rst,
  pat_req_if.sink   req,
  pat_rsp_if.source rsp
);

  localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  op_t              op_in;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             we;
  entry_t           rdata;
  entry_t           wdata;
  result_t          out_q;
  logic             out_valid;

  assign op_in.mode      = req.mode;
  assign op_in.node_id   = req.node_id;
  assign op_in.via       = req.via;
  assign op_in.epoch_now = req.epoch_now;
  assign op_in.slot      = req.slot;

  pat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PEERS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pat_ctrl #(
    .MAX_PEERS (MAX_PEERS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (req.valid),
    .op_ready  (req.ready),
    .op_in     (op_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .raddr     (raddr),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  // Hold the response until the sink takes it
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_q.status;
  assign rsp.found         = out_q.found;
  assign rsp.peer_state    = out_q.peer_state;
  assign rsp.may_open      = out_q.may_open;
  assign rsp.is_confirmed  = out_q.is_confirmed;
  assign rsp.transport_out = out_q.transport;
  assign rsp.verified_out  = out_q.verified;
  assign rsp.peer_out      = out_q.peer;
  assign rsp.count_out     = out_q.count;

endmodule

// ----- dv/peer_access_table_top_tb.sv -----
`timescale 1ns / 1ps

module peer_access_table_top_tb;
  import pat_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_OPS   = 1375;
  localparam int ID_POOL_SIZE = 24;
  localparam int IDLE_PCT     = 23;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 48;
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 549;
  localparam int HOLD_AT      = 800;
  localparam logic [3:0]  MODE_UNUSED_LAST = 4'd15;
  localparam logic [1:0]  VIA_RESERVED     = 2'd3;
  localparam logic [31:0] ID_TOP_VALID     = 32'hFFFF_FFFE;

  typedef struct packed {
    op_t     op;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  pat_req_if req_bus ();
  pat_rsp_if rsp_bus ();

  peer_access_table_top #(
    .MAX_PEERS(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Shadow copy of the peer table
  logic [31:0] tbl_id    [TABLE_DEPTH];
  logic [1:0]  tbl_trust [TABLE_DEPTH];
  logic [1:0]  tbl_via   [TABLE_DEPTH];
  logic [31:0] tbl_time  [TABLE_DEPTH];
  logic [4:0]  tbl_count;

  result_t     predicted_replies[$];
  dir_row_t    dir_rows[$];
  logic [31:0] id_pool[ID_POOL_SIZE];

  int errors;
  int requests_sent;
  int replies_checked;
  int full_rejects;
  int shifted_removes;
  int quiet_cycles;
  bit calm;
  bit hold_request;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_error(string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_field(int seq, string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("reply %0d %s got 0x%0h want 0x%0h", seq, name, got, want));
    end
  endtask

  function automatic void wipe_entry(int k);
    tbl_id[k]    = '0;
    tbl_trust[k] = TRUST_PENDING;
    tbl_via[k]   = VIA_NONE;
    tbl_time[k]  = '0;
  endfunction

  // Apply one request to the shadow table and return the reply it should give
  function automatic result_t peer_table_step(op_t op);
    result_t r;
    int      hit;
    int      used;
    int      k;
    logic    id_good;
    r       = '0;
    r.status = STATUS_OK;
    hit     = -1;
    used    = int'(tbl_count);
    id_good = (op.node_id != '0) && (op.node_id != ID_ALL_ONES);
    for (k = 0; k < used; k++) begin
      if (hit < 0 && tbl_id[k] == op.node_id) hit = k;
    end
    case (op.mode)
      MODE_LOOKUP, MODE_REMOVE, MODE_CONFIRM, MODE_DENY, MODE_PENDING: begin
        if (!id_good) begin
          r.status = STATUS_INVALID;
          hit = -1;
        end else if (hit < 0) begin
          r.status = STATUS_NOTFOUND;
        end else if (op.mode == MODE_REMOVE) begin
          // close the gap and clear the freed slot
          if (hit < used - 1) shifted_removes++;
          for (k = hit; k < used - 1; k++) begin
            tbl_id[k]    = tbl_id[k + 1];
            tbl_trust[k] = tbl_trust[k + 1];
            tbl_via[k]   = tbl_via[k + 1];
            tbl_time[k]  = tbl_time[k + 1];
          end
          tbl_count = tbl_count - 5'd1;
          wipe_entry(used - 1);
          hit = -1;
        end else if (op.mode == MODE_CONFIRM) begin
          tbl_trust[hit] = TRUST_CONFIRMED;
          tbl_via[hit]   = op.via;
          tbl_time[hit]  = op.epoch_now;
        end else if (op.mode == MODE_DENY) begin
          tbl_trust[hit] = TRUST_DENIED;
        end else if (op.mode == MODE_PENDING) begin
          tbl_trust[hit] = TRUST_PENDING;
        end
      end
      MODE_ADD: begin
        if (!id_good) begin
          r.status = STATUS_INVALID;
          hit = -1;
        end else if (hit >= 0) begin
          r.status = STATUS_PRESENT;
        end else if (used >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          wipe_entry(used);
          tbl_id[used] = op.node_id;
          tbl_count = tbl_count + 5'd1;
          hit = used;
        end
      end
      MODE_CLEAR: begin
        for (k = 0; k < TABLE_DEPTH; k++) wipe_entry(k);
        tbl_count = '0;
        hit = -1;
      end
      MODE_DEMOTE: begin
        for (k = 0; k < used; k++) begin
          if (tbl_trust[k] == TRUST_CONFIRMED) tbl_trust[k] = TRUST_PENDING;
        end
        hit = -1;
      end
      MODE_READ: begin
        if (int'(op.slot) < used) begin
          hit = int'(op.slot);
        end else begin
          r.status = STATUS_NOTFOUND;
          hit = -1;
        end
      end
      default: hit = -1;
    endcase
    // report the entry as it stands after the update
    if (hit >= 0) begin
      r.found        = 1'b1;
      r.peer_state   = tbl_trust[hit];
      r.may_open     = (tbl_trust[hit] != TRUST_DENIED);
      r.is_confirmed = (tbl_trust[hit] == TRUST_CONFIRMED);
      r.transport    = tbl_via[hit];
      r.verified     = tbl_time[hit];
      r.peer         = tbl_id[hit];
    end
    r.count = tbl_count;
    return r;
  endfunction

  // Reply readable at a glance: a fresh pending entry, or none when id is zero
  function automatic result_t glance(logic [2:0] status, logic [31:0] id, logic [4:0] count);
    result_t r;
    r        = '0;
    r.status = status;
    r.count  = count;
    if (id != '0) begin
      r.found      = 1'b1;
      r.peer_state = TRUST_PENDING;
      r.may_open   = 1'b1;
      r.peer       = id;
    end
    return r;
  endfunction

  task automatic plan(logic [3:0] mode, logic [31:0] id, logic [1:0] via,
                      logic [31:0] epoch, logic [3:0] slot, logic typed, result_t want);
    dir_row_t row;
    row.op    = {mode, id, via, epoch, slot};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Present one request, idling first at random, and predict its reply on acceptance
  task automatic offer(op_t op, output result_t predicted);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.mode      <= op.mode;
    req_bus.node_id   <= op.node_id;
    req_bus.via       <= op.via;
    req_bus.epoch_now <= op.epoch_now;
    req_bus.slot      <= op.slot;
    do @(posedge clk); while (!req_bus.ready);
    predicted = peer_table_step(op);
    requests_sent++;
  endtask

  // Watch for a hung handshake
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d replies outstanding",
               quiet_cycles, predicted_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Accept replies, check them, and drive ready with random stalls and one long hold
  initial begin
    result_t got;
    result_t want;
    int      hold_left;
    bit      hold_done;
    hold_left      = 0;
    hold_done      = 1'b0;
    rsp_bus.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        got              = '0;
        got.status       = rsp_bus.status;
        got.found        = rsp_bus.found;
        got.peer_state   = rsp_bus.peer_state;
        got.may_open     = rsp_bus.may_open;
        got.is_confirmed = rsp_bus.is_confirmed;
        got.transport    = rsp_bus.transport_out;
        got.verified     = rsp_bus.verified_out;
        got.peer         = rsp_bus.peer_out;
        got.count        = rsp_bus.count_out;
        if (predicted_replies.size() == 0) begin
          report_error($sformatf("unexpected reply, status %0d", got.status));
        end else begin
          want = predicted_replies.pop_front();
          if (want.status == STATUS_FULL) full_rejects++;
          check_field(replies_checked, "status", 32'(got.status), 32'(want.status));
          check_field(replies_checked, "found", 32'(got.found), 32'(want.found));
          check_field(replies_checked, "peer_state", 32'(got.peer_state),
                      32'(want.peer_state));
          check_field(replies_checked, "may_open", 32'(got.may_open), 32'(want.may_open));
          check_field(replies_checked, "is_confirmed", 32'(got.is_confirmed),
                      32'(want.is_confirmed));
          check_field(replies_checked, "transport_out", 32'(got.transport),
                      32'(want.transport));
          check_field(replies_checked, "verified_out", got.verified, want.verified);
          check_field(replies_checked, "peer_out", got.peer, want.peer);
          check_field(replies_checked, "count_out", 32'(got.count), 32'(want.count));
          replies_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Reset, directed table, random traffic, drain
  initial begin
    op_t     op;
    result_t want;
    int      pick;
    int      k;
    errors            = 0;
    requests_sent     = 0;
    replies_checked   = 0;
    full_rejects      = 0;
    shifted_removes   = 0;
    quiet_cycles      = 0;
    calm              = 1'b0;
    hold_request      = 1'b0;
    rst               = 1'b1;
    req_bus.valid     = 1'b0;
    req_bus.mode      = MODE_LOOKUP;
    req_bus.node_id   = '0;
    req_bus.via       = VIA_NONE;
    req_bus.epoch_now = '0;
    req_bus.slot      = '0;
    for (k = 0; k < TABLE_DEPTH; k++) wipe_entry(k);
    tbl_count = '0;

    // Draw a pool of ids so lookups hit and the table fills
    id_pool[0] = 32'h0000_0001;
    id_pool[1] = ID_TOP_VALID;
    for (k = 2; k < ID_POOL_SIZE; k++) begin
      do id_pool[k] = $urandom; while (id_pool[k] == '0 || id_pool[k] == ID_ALL_ONES);
    end

    // Directed requests: empty table, bad ids, trust changes, compaction, reads, an unused mode, clear
    plan(MODE_LOOKUP,  32'd5, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_NOTFOUND, '0, 5'd0));
    plan(MODE_READ,    '0, VIA_NONE, '0, 4'd15, 1'b1, glance(STATUS_NOTFOUND, '0, 5'd0));
    plan(MODE_ADD,     '0, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_INVALID, '0, 5'd0));
    plan(MODE_ADD,     ID_ALL_ONES, VIA_NONE, '0, 4'd0, 1'b1,
         glance(STATUS_INVALID, '0, 5'd0));
    plan(MODE_ADD,     32'd1, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_OK, 32'd1, 5'd1));
    plan(MODE_ADD,     ID_TOP_VALID, VIA_NONE, '0, 4'd0, 1'b1,
         glance(STATUS_OK, ID_TOP_VALID, 5'd2));
    plan(MODE_ADD,     32'h8000_0000, VIA_NONE, '0, 4'd0, 1'b1,
         glance(STATUS_OK, 32'h8000_0000, 5'd3));
    plan(MODE_ADD,     32'd1, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_CONFIRM, 32'd1, VIA_RESERVED, ID_ALL_ONES, 4'd0, 1'b0, '0);
    plan(MODE_CONFIRM, ID_TOP_VALID, 2'd2, '0, 4'd0, 1'b0, '0);
    plan(MODE_CONFIRM, 32'h8000_0000, 2'd1, 32'h5555_AAAA, 4'd0, 1'b0, '0);
    plan(MODE_DENY,    32'h8000_0000, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_LOOKUP,  32'h8000_0000, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_DEMOTE,  '0, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_LOOKUP,  32'd1, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_PENDING, 32'h8000_0000, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_REMOVE,  32'd1, VIA_NONE, '0, 4'd0, 1'b0, '0);
    plan(MODE_READ,    '0, VIA_NONE, '0, 4'd1, 1'b0, '0);
    plan(MODE_READ,    '0, VIA_NONE, '0, 4'd2, 1'b1, glance(STATUS_NOTFOUND, '0, 5'd2));
    plan(MODE_REMOVE,  32'd7, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_NOTFOUND, '0, 5'd2));
    plan(MODE_REMOVE,  '0, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_INVALID, '0, 5'd2));
    plan(MODE_DENY,    ID_ALL_ONES, VIA_NONE, '0, 4'd0, 1'b1,
         glance(STATUS_INVALID, '0, 5'd2));
    plan(MODE_PENDING, '0, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_INVALID, '0, 5'd2));
    plan(MODE_UNUSED_LAST, ID_TOP_VALID, VIA_RESERVED, ID_ALL_ONES, 4'd15, 1'b0, '0);
    plan(MODE_CLEAR,   '0, VIA_NONE, '0, 4'd0, 1'b1, glance(STATUS_OK, '0, 5'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].op, want);
      if (dir_rows[i].typed) want = dir_rows[i].want;
      predicted_replies.push_back(want);
    end

    // Random traffic, weighted toward adds so the table often runs full
    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= CALM_FIRST) && (n <= CALM_LAST);
      if (n == HOLD_AT) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        op.node_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
      end else if (pick < 90) begin
        op.node_id = '0;
      end else if (pick < 95) begin
        op.node_id = ID_ALL_ONES;
      end else begin
        op.node_id = $urandom;
      end
      op.via       = 2'($urandom_range(0, 3));
      op.epoch_now = $urandom;
      op.slot      = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 35)      op.mode = MODE_ADD;
      else if (pick < 45) op.mode = MODE_LOOKUP;
      else if (pick < 55) op.mode = MODE_REMOVE;
      else if (pick < 65) op.mode = MODE_CONFIRM;
      else if (pick < 72) op.mode = MODE_DENY;
      else if (pick < 78) op.mode = MODE_PENDING;
      else if (pick < 79) op.mode = MODE_CLEAR;
      else if (pick < 82) op.mode = MODE_DEMOTE;
      else if (pick < 95) op.mode = MODE_READ;
      else                op.mode = MODE_READ + 4'($urandom_range(1, 7));
      offer(op, want);
      predicted_replies.push_back(want);
    end
    calm = 1'b0;
    req_bus.valid <= 1'b0;

    // Drain outstanding replies, then watch for strays
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      report_error($sformatf("%0d replies never arrived", predicted_replies.size()));
    end

    $display("Summary: %0d requests (%0d directed), %0d replies checked",
             requests_sent, dir_rows.size(), replies_checked);
    $display("Summary: %0d table-full rejects, %0d compacting removes, %0d errors",
             full_rejects, shifted_removes, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pat_pkg.sv
rtl/core/pat_req_if.sv
rtl/core/pat_rsp_if.sv
rtl/core/pat_ram.sv
rtl/core/pat_ctrl.sv
rtl/core/peer_access_table_top.sv
dv/peer_access_table_top_tb.sv
